// ===== rtl/core/olr_pkg.sv =====
`timescale 1ns / 1ps

package olr_pkg;

    // plane size defaults
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // request and result field widths
    localparam int KIND_W  = 2;
    localparam int COORD_W = 16;
    localparam int MASK_W  = 8;
    localparam int RADDR_W = 16;

    // configuration
    localparam int DIM_W      = 9;
    localparam int NPIX_W     = 2 * DIM_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // coordinate difference and stepped point widths
    localparam int SPAN_W = COORD_W + 1;
    localparam int PT_W   = COORD_W + 2;

    localparam logic [DIM_W-1:0] ROW_WIDTH_RST = 9'd256;
    localparam logic [DIM_W-1:0] ROW_COUNT_RST = 9'd256;

    localparam logic signed [COORD_W-1:0] NO_POINT = -16'sd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_DRAW  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    // code with no operation behind it
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 4'd1;

    typedef enum logic [1:0] {
        OP_OR   = 2'd0,
        OP_ANDN = 2'd1,
        OP_READ = 2'd2
    } pix_op_t;

    typedef struct packed {
        logic    valid;
        pix_op_t op;
    } acc_ctl_t;

    typedef struct packed {
        logic init_busy;
        logic pipe_busy;
        logic rd_valid;
    } rmw_status_t;

    typedef struct packed {
        logic busy;
        logic skipped;
    } walk_status_t;

endpackage

// ===== rtl/core/olr_if.sv =====
`timescale 1ns / 1ps

interface olr_req_if import olr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [COORD_W-1:0] from_x;
    logic signed [COORD_W-1:0] from_y;
    logic signed [COORD_W-1:0] to_x;
    logic signed [COORD_W-1:0] to_y;
    logic [MASK_W-1:0]         mask_bits;
    logic [RADDR_W-1:0]        read_address;

    modport source (
        output valid, kind, from_x, from_y, to_x, to_y, mask_bits, read_address,
        input  ready
    );
    modport sink (
        input  valid, kind, from_x, from_y, to_x, to_y, mask_bits, read_address,
        output ready
    );
endinterface

interface olr_res_if import olr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] read_value;
    logic              line_skipped;

    modport source (output valid, read_value, line_skipped, input ready);
    modport sink (input valid, read_value, line_skipped, output ready);
endinterface

interface olr_cfg_if import olr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/olr_pixel_rmw.sv =====
`timescale 1ns / 1ps

module olr_pixel_rmw import olr_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT,
    localparam int ADDR_W    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  acc_ctl_t          acc_ctl,
    input  logic [ADDR_W-1:0] acc_addr,
    input  logic [MASK_W-1:0] acc_mask,
    output rmw_status_t       status,
    output logic [MASK_W-1:0] rd_data
);

    logic [MASK_W-1:0] mem [DEPTH];
    logic [MASK_W-1:0] rd_data_reg;

    logic              s1_valid_reg;
    pix_op_t           s1_op_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [MASK_W-1:0] s1_mask_reg;
    logic              fwd_hit_reg;
    logic [MASK_W-1:0] fwd_data_reg;

    logic              init_busy_reg;
    logic [ADDR_W-1:0] init_addr_reg;

    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [MASK_W-1:0] wr_data;
    logic [MASK_W-1:0] base;

    // write-back stage, a write to the entry just read is forwarded
    always_comb
    begin
        base    = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        rd_en   = acc_ctl.valid && !init_busy_reg;
        wr_en   = 1'b0;
        wr_addr = s1_addr_reg;
        wr_data = base;
        if (init_busy_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = init_addr_reg;
            wr_data = '0;
        end
        else if (s1_valid_reg)
        begin
            case (s1_op_reg)
                OP_OR:
                begin
                    wr_en   = 1'b1;
                    wr_data = base | s1_mask_reg;
                end
                OP_ANDN:
                begin
                    wr_en   = 1'b1;
                    wr_data = base & ~s1_mask_reg;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[acc_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg    <= acc_ctl.op;
        s1_addr_reg  <= acc_addr;
        s1_mask_reg  <= acc_mask;
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            init_busy_reg <= 1'b1;
            init_addr_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= rd_en;
            fwd_hit_reg  <= wr_en && (wr_addr == acc_addr);
            if (init_busy_reg)
            begin
                if (init_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    init_busy_reg <= 1'b0;
                end
                init_addr_reg <= init_addr_reg + 1'b1;
            end
        end
    end

    assign status.init_busy = init_busy_reg;
    assign status.pipe_busy = s1_valid_reg;
    assign status.rd_valid  = s1_valid_reg && (s1_op_reg == OP_READ);
    assign rd_data          = base;

endmodule

// ===== rtl/core/olr_line_walker.sv =====
`timescale 1ns / 1ps

module olr_line_walker import olr_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    localparam int ADDR_W    = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic signed [COORD_W-1:0] from_x,
    input  logic signed [COORD_W-1:0] from_y,
    input  logic signed [COORD_W-1:0] to_x,
    input  logic signed [COORD_W-1:0] to_y,
    input  logic [DIM_W-1:0]          eff_width,
    input  logic [NPIX_W-1:0]         npix,
    output walk_status_t              status,
    output acc_ctl_t                  acc_ctl,
    output logic [ADDR_W-1:0]         acc_addr
);

    localparam int PROD_W = PT_W + DIM_W + 1;
    localparam int POS_W  = PROD_W + 1;

    // load stage
    logic                      ld_valid_reg;
    logic signed [COORD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [COORD_W-1:0]        ax_reg, ay_reg;
    logic                      x_dn_reg, y_dn_reg;

    // stepping state
    logic                      walking_reg;
    logic                      skipped_reg;
    logic                      x_major_reg;
    logic                      neg_reg;
    logic signed [COORD_W-1:0] lo_major_reg, lo_minor_reg;
    logic [COORD_W-1:0]        span_reg, step_reg;
    logic [COORD_W-1:0]        t_reg, q_reg, r_reg;

    // point, product and address stages
    logic                      pt_valid_reg, pr_valid_reg, ac_valid_reg;
    logic signed [PT_W-1:0]    px_reg, py_reg, px2_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [ADDR_W-1:0]         ac_addr_reg;

    logic signed [SPAN_W-1:0]  dx, dy;
    logic [COORD_W-1:0]        ax, ay;
    logic                      x_major, skip, swap, minor_dn;
    logic signed [PT_W-1:0]    major_pt, minor_pt, q_ext;
    logic [SPAN_W-1:0]         rsum;
    logic signed [POS_W-1:0]   pos;
    logic                      in_range;

    always_comb
    begin
        dx = SPAN_W'(to_x) - SPAN_W'(from_x);
        dy = SPAN_W'(to_y) - SPAN_W'(from_y);
        ax = dx[SPAN_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
        ay = dy[SPAN_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
    end

    // setup: major axis, skip rules, low endpoint
    always_comb
    begin
        x_major  = ax_reg > ay_reg;
        skip     = x_major ? (x0_reg == NO_POINT)
                           : ((y0_reg == NO_POINT) || (ay_reg == '0));
        swap     = x_major ? x_dn_reg : y_dn_reg;
        minor_dn = x_major ? y_dn_reg : x_dn_reg;
    end

    // current point and remainder update
    always_comb
    begin
        q_ext    = $signed(PT_W'(q_reg));
        major_pt = PT_W'(lo_major_reg) + $signed(PT_W'(t_reg));
        minor_pt = PT_W'(lo_minor_reg) + (neg_reg ? -q_ext : q_ext);
        rsum     = SPAN_W'(r_reg) + SPAN_W'(step_reg);
    end

    always_comb
    begin
        pos      = POS_W'(px2_reg) + POS_W'(prod_reg);
        in_range = !pos[POS_W-1] && ($unsigned(pos) < POS_W'(npix));
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x0_reg   <= from_x;
            y0_reg   <= from_y;
            x1_reg   <= to_x;
            y1_reg   <= to_y;
            ax_reg   <= ax;
            ay_reg   <= ay;
            x_dn_reg <= to_x < from_x;
            y_dn_reg <= to_y < from_y;
        end

        if (ld_valid_reg)
        begin
            x_major_reg  <= x_major;
            neg_reg      <= swap ^ minor_dn;
            span_reg     <= x_major ? ax_reg : ay_reg;
            step_reg     <= x_major ? ay_reg : ax_reg;
            lo_major_reg <= x_major ? (swap ? x1_reg : x0_reg) : (swap ? y1_reg : y0_reg);
            lo_minor_reg <= x_major ? (swap ? y1_reg : y0_reg) : (swap ? x1_reg : x0_reg);
            t_reg        <= '0;
            q_reg        <= '0;
            r_reg        <= '0;
        end
        else if (walking_reg)
        begin
            t_reg <= t_reg + 1'b1;
            if (rsum >= SPAN_W'(span_reg))
            begin
                r_reg <= COORD_W'(rsum - SPAN_W'(span_reg));
                q_reg <= q_reg + 1'b1;
            end
            else
            begin
                r_reg <= COORD_W'(rsum);
            end
        end

        px_reg      <= x_major_reg ? major_pt : minor_pt;
        py_reg      <= x_major_reg ? minor_pt : major_pt;
        prod_reg    <= py_reg * $signed({1'b0, eff_width});
        px2_reg     <= px_reg;
        ac_addr_reg <= ADDR_W'($unsigned(pos));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_valid_reg <= 1'b0;
            walking_reg  <= 1'b0;
            skipped_reg  <= 1'b0;
            pt_valid_reg <= 1'b0;
            pr_valid_reg <= 1'b0;
            ac_valid_reg <= 1'b0;
        end
        else
        begin
            ld_valid_reg <= load;
            if (ld_valid_reg)
            begin
                walking_reg <= !skip;
                skipped_reg <= skip;
            end
            else if (walking_reg && (t_reg == span_reg))
            begin
                walking_reg <= 1'b0;
            end
            pt_valid_reg <= walking_reg && !ld_valid_reg;
            pr_valid_reg <= pt_valid_reg;
            ac_valid_reg <= pr_valid_reg && in_range;
        end
    end

    assign status.busy    = ld_valid_reg | walking_reg | pt_valid_reg
                          | pr_valid_reg | ac_valid_reg;
    assign status.skipped = skipped_reg;
    assign acc_ctl.valid  = ac_valid_reg;
    assign acc_ctl.op     = OP_OR;
    assign acc_addr       = ac_addr_reg;

endmodule

// ===== rtl/core/overlay_line_rasterizer.sv =====
`timescale 1ns / 1ps

// channel   dir   handshake      payload
// req       in    valid/ready    kind, from_x, from_y, to_x, to_y, mask_bits, read_address
// res       out   valid/ready    read_value, line_skipped
// cfg       in    valid/ready    index, data (0 row_width, 1 row_count)
//
// one request at a time; a draw that is not skipped walks its line at
// one pixel a cycle through the single read-modify-write port of the pixel memory
// after reset all MAX_WIDTH*MAX_HEIGHT pixel entries (65536 by default) are zeroed
// while req.ready stays low; cfg writes are taken throughout
// a result waits in the output register while the next request is already accepted

module overlay_line_rasterizer import olr_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input logic       clk,
    input logic       rst_n,
    olr_req_if.sink   req,
    olr_res_if.source res,
    olr_cfg_if.sink   cfg
);

    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);

    typedef enum logic [5:0] {
        ST_IDLE       = 6'b000001,
        ST_DRAW       = 6'b000010,
        ST_READ_ISSUE = 6'b000100,
        ST_READ_WAIT  = 6'b001000,
        ST_CLEAR      = 6'b010000,
        ST_FINISH     = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [DIM_W-1:0]  row_width_reg, row_count_reg;
    logic [DIM_W-1:0]  eff_width, eff_height;
    logic [NPIX_W-1:0] npix_reg;

    // per-request state
    logic [MASK_W-1:0]  mask_reg;
    logic [RADDR_W-1:0] raddr_reg;
    logic [NPIX_W-1:0]  sweep_reg;
    logic [MASK_W-1:0]  res_value_reg;
    logic               res_skip_reg;

    // output register
    logic               out_valid_reg;
    logic [MASK_W-1:0]  out_value_reg;
    logic               out_skip_reg;

    logic               req_fire;
    logic               out_load;
    logic               sweep_issue;

    acc_ctl_t           top_acc, walk_acc, rmw_acc;
    logic [ADDR_W-1:0]  top_addr, walk_addr, rmw_addr;
    rmw_status_t        rmw_status;
    walk_status_t       walk_status;
    logic [MASK_W-1:0]  rmw_rd_data;

    // config port never stalls
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RST;
            row_count_reg <= ROW_COUNT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_ROW_WIDTH: row_width_reg <= cfg.data[DIM_W-1:0];
                CFG_ROW_COUNT: row_count_reg <= cfg.data[DIM_W-1:0];
                default:       ;
            endcase
        end
    end

    // oversized dimensions clamp to the plane size
    always_comb
    begin
        eff_width  = (int'(row_width_reg) > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : row_width_reg;
        eff_height = (int'(row_count_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : row_count_reg;
    end

    assign req.ready = (state_reg == ST_IDLE) && !rmw_status.init_busy;
    assign req_fire  = req.valid && req.ready;
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || res.ready);

    // sequencer and access requests for read and clear
    always_comb
    begin
        state_next    = state_reg;
        top_acc.valid = 1'b0;
        top_acc.op    = OP_READ;
        top_addr      = ADDR_W'(sweep_reg);
        sweep_issue   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (kind_t'(req.kind))
                        KIND_DRAW:  state_next = ST_DRAW;
                        KIND_READ:  state_next = ST_READ_ISSUE;
                        KIND_CLEAR: state_next = ST_CLEAR;
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end
            ST_DRAW:
            begin
                // walker empty and last write-back done
                if (!walk_status.busy && !rmw_status.pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ_ISSUE:
            begin
                top_addr = ADDR_W'(raddr_reg);
                if (NPIX_W'(raddr_reg) < npix_reg)
                begin
                    top_acc.valid = 1'b1;
                    state_next    = ST_READ_WAIT;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ_WAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_CLEAR:
            begin
                // one pixel a cycle over the plane in use
                if (sweep_reg < npix_reg)
                begin
                    top_acc.valid = 1'b1;
                    top_acc.op    = OP_ANDN;
                    sweep_issue   = 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_fire)
            begin
                sweep_reg <= '0;
            end
            else if (sweep_issue)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        npix_reg <= eff_width * eff_height;
        if (req_fire)
        begin
            mask_reg      <= req.mask_bits;
            raddr_reg     <= req.read_address;
            res_value_reg <= '0;
            res_skip_reg  <= 1'b0;
        end
        if (state_reg == ST_READ_WAIT)
        begin
            res_value_reg <= rmw_rd_data;
        end
        if (state_reg == ST_DRAW)
        begin
            res_skip_reg <= walk_status.skipped;
        end
        if (out_load)
        begin
            out_value_reg <= res_value_reg;
            out_skip_reg  <= res_skip_reg;
        end
    end

    // the walker owns the memory port while a line is drawn
    assign rmw_acc  = (state_reg == ST_DRAW) ? walk_acc  : top_acc;
    assign rmw_addr = (state_reg == ST_DRAW) ? walk_addr : top_addr;

    olr_line_walker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (req_fire && (req.kind == KIND_DRAW)),
        .from_x    (req.from_x),
        .from_y    (req.from_y),
        .to_x      (req.to_x),
        .to_y      (req.to_y),
        .eff_width (eff_width),
        .npix      (npix_reg),
        .status    (walk_status),
        .acc_ctl   (walk_acc),
        .acc_addr  (walk_addr)
    );

    olr_pixel_rmw #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_rmw (
        .clk      (clk),
        .rst_n    (rst_n),
        .acc_ctl  (rmw_acc),
        .acc_addr (rmw_addr),
        .acc_mask (mask_reg),
        .status   (rmw_status),
        .rd_data  (rmw_rd_data)
    );

    assign res.valid        = out_valid_reg;
    assign res.read_value   = out_value_reg;
    assign res.line_skipped = out_skip_reg;

endmodule

// ===== rtl/core/olr_checker.sv =====
`timescale 1ns / 1ps

module olr_checker import olr_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic [KIND_W-1:0] req_kind,
    input logic              res_valid,
    input logic              res_ready,
    input logic [MASK_W-1:0] res_read_value,
    input logic              res_line_skipped
);

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_read_value)
                                    && $stable(res_line_skipped))
        else $error("result changed while stalled");

    // one request in flight
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // memory clearing pass keeps requests out after reset
    a_reset_blocks: assert property (@(posedge clk)
        !rst_n |=> !req_ready)
        else $error("request port open during clearing pass");

    // unused kind gives an empty result through the finish state and the output register
    a_unused_kind: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_kind == KIND_UNUSED) && !res_valid
        |=> ##1 res_valid && (res_read_value == '0) && !res_line_skipped)
        else $error("unused kind result wrong or late");

endmodule

bind overlay_line_rasterizer olr_checker u_olr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_kind         (req.kind),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_read_value   (res.read_value),
    .res_line_skipped (res.line_skipped)
);
